@@ hw/rtl/kfct_pkg.sv @@
// ----------------------------------------------------------------------------
// kfct_pkg
// Shared types, codes and widths of the keyed count tree.
// ----------------------------------------------------------------------------
package kfct_pkg;

  localparam int FUNC_W  = 2;
  localparam int TIME_W  = 11;
  localparam int KEY_W   = 8;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 11;
  // node must hold limit plus its lowest set bit
  localparam int NODE_W  = CFG_W + 1;

  localparam int DEF_TIME_SLOTS = 1024;
  localparam int DEF_KEY_COUNT  = 256;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(1024);

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;
  localparam func_t FUNC_NONE   = 2'd3;

  typedef struct packed {
    logic load;
    logic up;
    logic step;
  } walk_ctrl_t;

endpackage

@@ hw/rtl/keyed_fenwick_count_tree_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_fenwick_count_tree_unit
// Binary indexed tree over time slots with one 32-bit count per key.
//
// An item is transferred at a clock edge with start high and busy low.
// func add or remove walks up from time_index and adjusts the key's count
// at each node; func query walks down and returns the sum of the key's
// counts on count, marked by done for exactly one cycle. Add and remove
// return nothing, neither does the unused code.
// Each visited node takes one read on the single read port of the count
// store; the update's write-back overlaps the read of the next node.
// busy stays high until the walk is through, so a new item can only be
// transferred once the last one is finished.
// cfg_we must write slots_in_use (reset 1024) only while the unit is idle;
// the unit itself does not enforce it. After reset the unit clears all
// TIME_SLOTS * KEY_COUNT words of the count store (262144 by default),
// one word per cycle, with busy held high.
// The receiver cannot stall: done appears for one cycle only, and count
// changes at the end of every later item.
// ----------------------------------------------------------------------------
module keyed_fenwick_count_tree_unit #(
  parameter int TIME_SLOTS = kfct_pkg::DEF_TIME_SLOTS,
  parameter int KEY_COUNT  = kfct_pkg::DEF_KEY_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [kfct_pkg::FUNC_W-1:0]         func,
  input  logic [kfct_pkg::TIME_W-1:0]         time_index,
  input  logic [kfct_pkg::KEY_W-1:0]          key,
  output logic                                done,
  output logic signed [kfct_pkg::COUNT_W-1:0] count,
  input  logic                                cfg_we,
  input  logic [kfct_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int DEPTH = TIME_SLOTS * KEY_COUNT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                         state;
  logic [AW-1:0]                  clr_addr;
  logic [kfct_pkg::CFG_W-1:0]     slots_in_use;
  kfct_pkg::func_t                func_q;
  logic [kfct_pkg::KEY_W-1:0]     key_q;
  logic [kfct_pkg::COUNT_W-1:0]   sum;
  logic                           pend;
  logic [AW-1:0]                  addr_q;

  logic [kfct_pkg::NODE_W-1:0]    limit;
  logic [kfct_pkg::NODE_W-1:0]    query_node;
  logic [kfct_pkg::NODE_W-1:0]    start_node;
  logic                           key_ok;
  logic                           accept;
  kfct_pkg::walk_ctrl_t           walk_ctrl;
  logic                           node_valid;
  logic [AW-1:0]                  walk_addr;
  logic                           is_query;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [kfct_pkg::COUNT_W-1:0]   ram_wdata;
  logic [kfct_pkg::COUNT_W-1:0]   ram_rdata;
  logic [kfct_pkg::COUNT_W-1:0]   acc_out;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign limit = (32'(slots_in_use) > TIME_SLOTS) ? kfct_pkg::NODE_W'(TIME_SLOTS)
                                                   : kfct_pkg::NODE_W'(slots_in_use);
  assign query_node = (kfct_pkg::NODE_W'(time_index) > limit) ? limit
                                                               : kfct_pkg::NODE_W'(time_index);
  assign key_ok = (32'(key) < KEY_COUNT);
  assign start_node = !key_ok ? '0
                    : (func == kfct_pkg::FUNC_QUERY) ? query_node
                    : kfct_pkg::NODE_W'(time_index);

  assign is_query = (func_q == kfct_pkg::FUNC_QUERY);

  assign walk_ctrl.load = accept && (func != kfct_pkg::FUNC_NONE);
  assign walk_ctrl.up   = (func != kfct_pkg::FUNC_QUERY);
  assign walk_ctrl.step = (state == ST_WALK) && node_valid;

  assign ram_we    = (state == ST_CLEAR) || ((state == ST_WALK) && pend && !is_query);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : addr_q;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : acc_out;

  kfct_node_walker #(
    .KEY_COUNT (KEY_COUNT),
    .AW        (AW)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (walk_ctrl),
    .start_node (start_node),
    .limit      (limit),
    .key        (key_q),
    .node_valid (node_valid),
    .addr       (walk_addr)
  );

  kfct_count_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (walk_ctrl.step),
    .raddr (walk_addr),
    .rdata (ram_rdata)
  );

  kfct_accum u_accum (
    .add_sum (is_query),
    .minus   (func_q == kfct_pkg::FUNC_REMOVE),
    .sum     (sum),
    .rdata   (ram_rdata),
    .result  (acc_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= kfct_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          done     <= 1'b0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          done <= 1'b0;
          if (walk_ctrl.load) begin
            func_q <= func;
            key_q  <= key;
            sum    <= '0;
            pend   <= 1'b0;
            state  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (pend && is_query) begin
            sum <= acc_out;
          end
          if (node_valid) begin
            addr_q <= walk_addr;
            pend   <= 1'b1;
          end else begin
            pend  <= 1'b0;
            done  <= is_query;
            count <= signed'(pend ? acc_out : sum);
            state <= ST_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/kfct_count_ram.sv @@
// ----------------------------------------------------------------------------
// kfct_count_ram
// Count store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kfct_count_ram #(
  parameter int DEPTH = kfct_pkg::DEF_TIME_SLOTS * kfct_pkg::DEF_KEY_COUNT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [kfct_pkg::COUNT_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [kfct_pkg::COUNT_W-1:0] rdata
);

  logic [kfct_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/kfct_node_walker.sv @@
// ----------------------------------------------------------------------------
// kfct_node_walker
// Tree node register: steps up or down by the lowest set bit and forms
// the store address of the current node and key.
// ----------------------------------------------------------------------------
module kfct_node_walker #(
  parameter int KEY_COUNT = kfct_pkg::DEF_KEY_COUNT,
  parameter int AW        = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kfct_pkg::walk_ctrl_t        ctrl,
  input  logic [kfct_pkg::NODE_W-1:0] start_node,
  input  logic [kfct_pkg::NODE_W-1:0] limit,
  input  logic [kfct_pkg::KEY_W-1:0]  key,
  output logic                        node_valid,
  output logic [AW-1:0]               addr
);

  localparam int PW = AW + kfct_pkg::NODE_W;

  logic [kfct_pkg::NODE_W-1:0] node;
  logic [kfct_pkg::NODE_W-1:0] node_next;
  logic [kfct_pkg::NODE_W-1:0] low_bit;
  logic [kfct_pkg::NODE_W-1:0] node_m1;
  logic [PW-1:0]               row_base;
  logic                        up;

  assign low_bit = node & (~node + 1'b1);
  assign node_m1 = node - 1'b1;
  assign node_next = up ? (node + low_bit) : (node & node_m1);
  assign node_valid = (node != '0) && (!up || (node <= limit));

  assign row_base = PW'(node_m1) * PW'(KEY_COUNT);
  assign addr = AW'(row_base) + AW'(key);

  always_ff @(posedge clk) begin
    if (rst) begin
      node <= '0;
      up   <= 1'b0;
    end else if (ctrl.load) begin
      node <= start_node;
      up   <= ctrl.up;
    end else if (ctrl.step) begin
      node <= node_next;
    end
  end

endmodule

@@ hw/rtl/kfct_accum.sv @@
// ----------------------------------------------------------------------------
// kfct_accum
// Shared 32-bit adder: read count plus running sum or plus/minus one.
// ----------------------------------------------------------------------------
module kfct_accum (
  input  logic                         add_sum,
  input  logic                         minus,
  input  logic [kfct_pkg::COUNT_W-1:0] sum,
  input  logic [kfct_pkg::COUNT_W-1:0] rdata,
  output logic [kfct_pkg::COUNT_W-1:0] result
);

  logic [kfct_pkg::COUNT_W-1:0] delta;
  logic [kfct_pkg::COUNT_W-1:0] operand;

  assign delta   = minus ? '1 : kfct_pkg::COUNT_W'(1);
  assign operand = add_sum ? sum : delta;
  assign result  = operand + rdata;

endmodule

@@ hw/rtl/kfct_checker.sv @@
// ----------------------------------------------------------------------------
// kfct_checker
// Port-level checks of the count tree unit, bound to the top level.
// ----------------------------------------------------------------------------
module kfct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [kfct_pkg::FUNC_W-1:0] func,
  input logic                        done
);

  // reset starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("unit not busy after reset");

  // a real operation sets busy right after its transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func != kfct_pkg::FUNC_NONE)) |=> busy)
    else $error("busy low right after transfer");

  // a result never follows its transfer in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result one cycle after transfer");

  // results come only at the end of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without preceding work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind keyed_fenwick_count_tree_unit kfct_checker u_kfct_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);
